// ----- design/tcp_connection_state_tracker_assert.svh -----
// Assertion macros for the TCP connection state tracker checkers.
// No dependencies; included by the checker file.
`ifndef TCP_CONNECTION_STATE_TRACKER_ASSERT_SVH
`define TCP_CONNECTION_STATE_TRACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TCPST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpst: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TCPST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpst: next-cycle check failed");

`endif

// ----- design/tcpst_pkg.sv -----
// Package for the TCP connection state tracker: payload, command and state types.
// No dependencies.
`default_nettype none

package tcpst_pkg;

   localparam int NUM_STATES  = 8;
   localparam int STATE_W     = 3;
   localparam int KEY_W       = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [STATE_W-1:0] {
      ST_SYN_SENT = 3'd0,
      ST_SYN_RCVD = 3'd1,
      ST_ESTAB    = 3'd2,
      ST_FINW1    = 3'd3,
      ST_FINW2    = 3'd4,
      ST_CLOSEW   = 3'd5,
      ST_LASTACK  = 3'd6,
      ST_TIMEW    = 3'd7
   } conn_state_type;

   typedef struct packed {
      logic             from_internet;
      logic [KEY_W-1:0] flow_hash;
      logic             syn_flag;
      logic             ack_flag;
      logic             fin_flag;
      logic             rst_flag;
      logic             source_known;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic                 session_found;
      logic [STATE_W-1:0]   new_state;
      logic                 table_full;
   } rsp_type;

   typedef struct packed {
      logic                 acc;
      logic [STATE_W-1:0]   nxt;
   } rule_out_type;

   // classified packet: per-state verdict for the hit case, plus miss handling
   typedef struct packed {
      logic [KEY_W-1:0]                     key;
      logic [NUM_STATES-1:0]                rule_acc;
      logic [NUM_STATES-1:0][STATE_W-1:0]   rule_nxt;
      logic                                 miss_acc;
      logic                                 miss_open;
   } cmd_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

// ----- design/tcpst_front.sv -----
// Front end: takes a packet summary and classifies it into a command.
// Depends on tcpst_pkg.
`default_nettype none

module tcpst_front import tcpst_pkg::*; (
   input  wire logic    start,
   input  wire req_type req_payload,
   input  wire logic    q_full,
   output logic         busy,
   output logic         push,
   output cmd_type      cmd
);

   function automatic rule_out_type apply_rule(
      input logic           inbound,
      input conn_state_type cur,
      input logic           syn,
      input logic           ack,
      input logic           fin,
      input logic           rst
   );
      rule_out_type r;
      r.acc = 1'b0;
      r.nxt = cur;
      if (rst) begin
         r.acc = 1'b1;
         r.nxt = ST_TIMEW;
      end else if (!inbound) begin
         case (cur)
            ST_SYN_SENT: r.acc = syn;
            ST_SYN_RCVD: begin
               if (ack && !fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_ESTAB;
               end
            end
            ST_ESTAB: begin
               if (fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_FINW1;
               end else begin
                  r.acc = ack;
               end
            end
            ST_FINW1:   r.acc = fin | ack;
            ST_FINW2:   r.acc = ack;
            ST_CLOSEW: begin
               if (fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_LASTACK;
               end else begin
                  r.acc = ack;
               end
            end
            ST_LASTACK: r.acc = fin;
            ST_TIMEW:   r.acc = ack;
            default:    r.acc = 1'b0;
         endcase
      end else begin
         case (cur)
            ST_SYN_SENT: begin
               if (syn && ack) begin
                  r.acc = 1'b1;
                  r.nxt = ST_SYN_RCVD;
               end
            end
            ST_SYN_RCVD: r.acc = syn & ack;
            ST_ESTAB: begin
               if (fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_CLOSEW;
               end else begin
                  r.acc = ack;
               end
            end
            ST_FINW1: begin
               if (ack && !fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_FINW2;
               end else if (ack && fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_TIMEW;
               end
            end
            ST_FINW2: begin
               if (fin) begin
                  r.acc = 1'b1;
                  r.nxt = ST_TIMEW;
               end else begin
                  r.acc = ack;
               end
            end
            ST_CLOSEW:  r.acc = fin | ack;
            ST_LASTACK: begin
               if (ack) begin
                  r.acc = 1'b1;
                  r.nxt = ST_TIMEW;
               end
            end
            ST_TIMEW:   r.acc = ack | fin;
            default:    r.acc = 1'b0;
         endcase
      end
      return r;
   endfunction

   assign busy = q_full;
   assign push = start && !q_full;

   always_comb begin
      rule_out_type ro;
      cmd.key = req_payload.flow_hash;
      for (int s = 0; s < NUM_STATES; s++) begin
         ro = apply_rule(req_payload.from_internet, conn_state_type'(s[STATE_W-1:0]),
                         req_payload.syn_flag, req_payload.ack_flag,
                         req_payload.fin_flag, req_payload.rst_flag);
         cmd.rule_acc[s] = ro.acc;
         cmd.rule_nxt[s] = ro.nxt;
      end
      cmd.miss_acc  = req_payload.from_internet ? req_payload.source_known
                                                : req_payload.syn_flag;
      cmd.miss_open = !req_payload.from_internet && req_payload.syn_flag;
   end

endmodule

`default_nettype wire

// ----- design/tcpst_queue.sv -----
// Short command queue between front end and session engine.
// Depends on tcpst_pkg.
`default_nettype none

module tcpst_queue import tcpst_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_FULL);
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- design/tcpst_back.sv -----
// Session engine: scans the session memory, applies the verdict, writes back.
// Depends on tcpst_pkg.
`default_nettype none

module tcpst_back import tcpst_pkg::*; #(
   parameter int SESSIONS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(SESSIONS);
   localparam int CNT_W = $clog2(SESSIONS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SESSIONS);

   // sessions occupy slots 0 .. fill-1; nothing is ever removed
   logic [KEY_W-1:0]    key_mem [SESSIONS];
   logic [STATE_W-1:0]  st_mem  [SESSIONS];

   back_state_type      bstate_ff, bstate_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                chk_ff, chk_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [KEY_W-1:0]    rd_key_ff;
   logic [STATE_W-1:0]  rd_st_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                match, miss, issue, wr_en;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   logic [KEY_W-1:0]    wr_key;
   logic [STATE_W-1:0]  wr_st;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      match = (bstate_ff == BK_SCAN) && chk_ff && (rd_key_ff == cmd_ff.key);
      miss  = (bstate_ff == BK_SCAN) && !match && (scan_ff == fill_ff);
      issue = (bstate_ff == BK_SCAN) && !match && (scan_ff < fill_ff);
      rd_addr = issue ? scan_ff[IDX_W-1:0] : '0;

      bstate_in    = bstate_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_key       = cmd_ff.key;
      wr_st        = cmd_ff.rule_nxt[rd_st_ff];

      case (bstate_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               scan_in   = '0;
               bstate_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (issue) begin
               scan_in    = scan_ff + 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
            end
            if (match) begin
               wr_en                = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.accepted      = cmd_ff.rule_acc[rd_st_ff];
               rsp_in.session_found = 1'b1;
               rsp_in.new_state     = cmd_ff.rule_nxt[rd_st_ff];
               rsp_in.table_full    = 1'b0;
               bstate_in            = BK_IDLE;
            end else if (miss) begin
               rsp_valid_in         = 1'b1;
               rsp_in.accepted      = cmd_ff.miss_acc;
               rsp_in.session_found = 1'b0;
               rsp_in.new_state     = ST_SYN_SENT;
               rsp_in.table_full    = 1'b0;
               if (cmd_ff.miss_open) begin
                  if (fill_ff == CNT_MAX) begin
                     rsp_in.accepted   = 1'b0;
                     rsp_in.table_full = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = fill_ff[IDX_W-1:0];
                     wr_st   = ST_SYN_SENT;
                     fill_in = fill_ff + 1'b1;
                  end
               end
               bstate_in = BK_IDLE;
            end
         end
         default: bstate_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= BK_IDLE;
         fill_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         fill_ff      <= fill_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         st_mem[wr_addr]  <= wr_st;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_st_ff  <= st_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/tcp_connection_state_tracker.sv -----
// Top level of the TCP connection state tracker: front end, queue, session engine.
// Depends on tcpst_pkg, tcpst_front, tcpst_queue, tcpst_back.
//
//   channel   | ports                              | transfer when
//   ----------+------------------------------------+-------------------------
//   request   | start, busy, req_payload           | start && !busy at edge
//   response  | rsp_valid, rsp_payload             | rsp_valid high, one cycle
//
// The session engine scans the stored sessions, fill being their number: the key memory's
// single read port is scanned one slot a cycle, so the scan stops after slot k on a hit in
// slot k and after all fill slots on a miss. Responses never come back to back. The queue
// holds two packets; busy is high while it is full. Reset empties the table at once (a fill
// count, no clearing pass). The response side cannot stall.
`default_nettype none

module tcp_connection_state_tracker import tcpst_pkg::*; #(
   parameter int SESSIONS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   logic    push, pop, q_full, q_not_empty;
   cmd_type front_cmd, head_cmd;

   tcpst_front u_front (
      .start       (start),
      .req_payload (req_payload),
      .q_full      (q_full),
      .busy        (busy),
      .push        (push),
      .cmd         (front_cmd)
   );

   tcpst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   tcpst_back #(
      .SESSIONS (SESSIONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- design/tcpst_checker.sv -----
// Port-level checks for the TCP connection state tracker, bound to the top level.
// Depends on tcpst_pkg and tcp_connection_state_tracker_assert.svh.
`default_nettype none

`include "tcp_connection_state_tracker_assert.svh"

module tcpst_checker import tcpst_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_payload
);

   `TCPST_ASSERT_NXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid)
   `TCPST_ASSERT_IMP(a_full_blocks, clock, reset, rsp_valid && rsp_payload.table_full,
      !rsp_payload.accepted && !rsp_payload.session_found && rsp_payload.new_state == ST_SYN_SENT)
   `TCPST_ASSERT_IMP(a_miss_state, clock, reset, rsp_valid && !rsp_payload.session_found,
      rsp_payload.new_state == ST_SYN_SENT)
   `TCPST_ASSERT_IMP(a_post_reset, clock, reset, $past(reset), !busy && !rsp_valid)

endmodule

bind tcp_connection_state_tracker tcpst_checker u_tcpst_checker (.*);

`default_nettype wire

// ----- test/tcp_connection_state_tracker_tb.sv -----
// Self-checking testbench for tcp_connection_state_tracker: session-table scoreboard,
// packet driver and verdict monitor. Depends on tcpst_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tcp_connection_state_tracker_tb;
   import tcpst_pkg::*;

   localparam int SESSIONS     = 64;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 200;
   localparam int SHOWN_ERRORS = 20;

   class session_scoreboard;
      bit             slot_used[SESSIONS];
      logic [31:0]    slot_key[SESSIONS];
      conn_state_type slot_state[SESSIONS];
      rsp_type        pending_verdicts[$];
      int             errors;
      int             packets;
      int             checked;
      int             stored;
      int             refusals;

      function int lookup(logic [31:0] k);
         for (int i = 0; i < SESSIONS; i++)
            if (slot_used[i] && slot_key[i] == k) return i;
         return -1;
      endfunction

      function bit outbound_transition(conn_state_type cur, logic syn, logic ack, logic fin,
                                       logic rst, output conn_state_type nxt);
         nxt = cur;
         if (rst) begin
            nxt = ST_TIMEW;
            return 1'b1;
         end
         case (cur)
            ST_SYN_SENT: return syn;
            ST_SYN_RCVD: begin
               if (ack && !fin) begin
                  nxt = ST_ESTAB;
                  return 1'b1;
               end
            end
            ST_ESTAB: begin
               if (fin) begin
                  nxt = ST_FINW1;
                  return 1'b1;
               end
               return ack;
            end
            ST_FINW1:   return fin || ack;
            ST_FINW2:   return ack;
            ST_CLOSEW: begin
               if (fin) begin
                  nxt = ST_LASTACK;
                  return 1'b1;
               end
               return ack;
            end
            ST_LASTACK: return fin;
            ST_TIMEW:   return ack;
            default:    return 1'b0;
         endcase
         return 1'b0;
      endfunction

      function bit inbound_transition(conn_state_type cur, logic syn, logic ack, logic fin,
                                      logic rst, output conn_state_type nxt);
         nxt = cur;
         if (rst) begin
            nxt = ST_TIMEW;
            return 1'b1;
         end
         case (cur)
            ST_SYN_SENT: begin
               if (syn && ack) begin
                  nxt = ST_SYN_RCVD;
                  return 1'b1;
               end
            end
            ST_SYN_RCVD: return syn && ack;
            ST_ESTAB: begin
               if (fin) begin
                  nxt = ST_CLOSEW;
                  return 1'b1;
               end
               return ack;
            end
            ST_FINW1: begin
               if (ack && !fin) begin
                  nxt = ST_FINW2;
                  return 1'b1;
               end
               if (ack && fin) begin
                  nxt = ST_TIMEW;
                  return 1'b1;
               end
            end
            ST_FINW2: begin
               if (fin) begin
                  nxt = ST_TIMEW;
                  return 1'b1;
               end
               return ack;
            end
            ST_CLOSEW:  return fin || ack;
            ST_LASTACK: begin
               if (ack) begin
                  nxt = ST_TIMEW;
                  return 1'b1;
               end
            end
            ST_TIMEW:   return ack || fin;
            default:    return 1'b0;
         endcase
         return 1'b0;
      endfunction

      // predict the verdict of one accepted packet and update the session table
      function void note_packet(req_type p);
         rsp_type        v;
         int             hit;
         int             free_slot;
         conn_state_type nxt;
         v = '0;
         hit = lookup(p.flow_hash);
         free_slot = -1;
         for (int i = 0; i < SESSIONS; i++) begin
            if (!slot_used[i]) begin
               free_slot = i;
               break;
            end
         end
         if (hit >= 0) begin
            v.session_found = 1'b1;
            if (p.from_internet)
               v.accepted = inbound_transition(slot_state[hit], p.syn_flag, p.ack_flag,
                                               p.fin_flag, p.rst_flag, nxt);
            else
               v.accepted = outbound_transition(slot_state[hit], p.syn_flag, p.ack_flag,
                                                p.fin_flag, p.rst_flag, nxt);
            slot_state[hit] = nxt;
            v.new_state = nxt;
         end else if (p.from_internet) begin
            v.accepted = p.source_known;
         end else if (p.syn_flag) begin
            if (free_slot >= 0) begin
               slot_used[free_slot]  = 1'b1;
               slot_key[free_slot]   = p.flow_hash;
               slot_state[free_slot] = ST_SYN_SENT;
               v.accepted = 1'b1;
               stored++;
            end else begin
               v.table_full = 1'b1;
               refusals++;
            end
         end
         pending_verdicts.push_back(v);
         packets++;
      endfunction

      task report_mismatch(string what, int got, int want);
         if (errors < SHOWN_ERRORS)
            $display("%0t: verdict %0d, %s: got %0d, expected %0d",
                     $realtime, checked, what, got, want);
         errors++;
      endtask

      task check_verdict(rsp_type got);
         rsp_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", got.accepted, want.accepted);
            if (got.session_found !== want.session_found)
               report_mismatch("session_found", got.session_found, want.session_found);
            if (got.new_state !== want.new_state)
               report_mismatch("new_state", got.new_state, want.new_state);
            if (got.table_full !== want.table_full)
               report_mismatch("table_full", got.table_full, want.table_full);
         end
         checked++;
      endtask

      function int pending();
         return pending_verdicts.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   session_scoreboard sb;
   int cycle_count = 0;
   int burst_left  = 0;

   tcp_connection_state_tracker #(.SESSIONS(SESSIONS)) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tcp_connection_state_tracker_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_verdict(rsp_payload);
   end

   function automatic req_type pkt(logic dir, logic [31:0] k, logic syn, logic ack,
                                   logic fin, logic rst, logic known);
      req_type p;
      p.from_internet = dir;
      p.flow_hash     = k;
      p.syn_flag      = syn;
      p.ack_flag      = ack;
      p.fin_flag      = fin;
      p.rst_flag      = rst;
      p.source_known  = known;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = $urandom_range(10, 40);
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // start stays high between back-to-back transfers
   task automatic send_packet(req_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (busy);
      sb.note_packet(p);
   endtask

   task automatic wait_all_verdicts();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // a packet that moves the session along its usual path
   function automatic req_type well_formed(logic [31:0] k, conn_state_type st);
      int      pick;
      req_type p;
      pick = $urandom_range(0, 3);
      p = pkt(1'b0, k, 1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) == 0) begin
         p.rst_flag      = 1'b1;
         p.from_internet = 1'($urandom_range(0, 1));
         return p;
      end
      case (st)
         ST_SYN_SENT: begin
            p.from_internet = 1'b1;
            p.syn_flag      = 1'b1;
            p.ack_flag      = 1'b1;
         end
         ST_SYN_RCVD: begin
            p.ack_flag = 1'b1;
            if (pick == 0) begin
               p.from_internet = 1'b1;
               p.syn_flag      = 1'b1;
            end
         end
         ST_ESTAB: begin
            p.from_internet = pick[0];
            p.ack_flag      = 1'b1;
            p.fin_flag      = pick[1];
         end
         ST_FINW1: begin
            p.from_internet = (pick != 0);
            p.ack_flag      = (pick != 3);
            p.fin_flag      = (pick >= 2);
         end
         ST_FINW2: begin
            p.from_internet = (pick != 0);
            p.ack_flag      = (pick == 0 || pick == 3) ? 1'b1 : 1'($urandom_range(0, 1));
            p.fin_flag      = (pick == 1 || pick == 2);
         end
         ST_CLOSEW: begin
            p.from_internet = (pick == 1);
            p.ack_flag      = (pick < 2) ? 1'b1 : 1'($urandom_range(0, 1));
            p.fin_flag      = (pick >= 2);
         end
         ST_LASTACK: begin
            p.from_internet = (pick != 0);
            p.ack_flag      = (pick != 0);
            p.fin_flag      = (pick == 0);
         end
         default: begin
            p.from_internet = pick[0];
            p.ack_flag      = 1'b1;
            p.fin_flag      = pick[1];
         end
      endcase
      return p;
   endfunction

   function automatic req_type random_packet();
      int          r;
      int          idx;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      if (r < 12 || sb.stored == 0)
         return pkt(1'b0, $urandom, 1'b1, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
      if (r < 78) begin
         idx = $urandom_range(0, sb.stored - 1);
         for (int t = 0; t < 4 && sb.slot_state[idx] == ST_TIMEW; t++)
            idx = $urandom_range(0, sb.stored - 1);
         return well_formed(sb.slot_key[idx], sb.slot_state[idx]);
      end
      k = $urandom_range(0, 1) ? sb.slot_key[$urandom_range(0, sb.stored - 1)] : $urandom;
      return pkt(1'($urandom_range(0, 1)), k, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endfunction

   initial begin
      sb = new;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full handshake and active close on key zero
      send_packet(pkt(1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
      send_packet(pkt(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_packet(pkt(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      // passive close on the all-ones key, with a blocked packet on the way
      send_packet(pkt(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      send_packet(pkt(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_packet(pkt(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      // misses: outbound without SYN, inbound with known and unknown source
      send_packet(pkt(1'b0, 32'h5A5A_A5A5, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
      send_packet(pkt(1'b1, 32'h5A5A_A5A5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_packet(pkt(1'b1, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      // a SYN miss with RST set, an inbound miss, then reset of a fresh session and a blocked SYN in time-wait
      send_packet(pkt(1'b0, 32'h8000_0001, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
      send_packet(pkt(1'b1, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_packet(pkt(1'b0, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_packet(pkt(1'b1, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_packet(pkt(1'b0, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

      repeat (300) send_packet(random_packet());

      wait_all_verdicts();

      // fill the session table, then overflow it
      while (sb.stored < SESSIONS)
         send_packet(pkt(1'b0, $urandom, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0,
                         1'($urandom_range(0, 1))));
      repeat (4)
         send_packet(pkt(1'b0, $urandom, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

      repeat (300) send_packet(random_packet());

      wait_all_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d packets, %0d verdicts checked, %0d sessions opened,",
               sb.packets, sb.checked, sb.stored);
      $display("%0d refused on a full table, %0d mismatches", sb.refusals, sb.errors);
      if (sb.errors == 0)
         $display("tcp_connection_state_tracker_tb: done, clean");
      else
         $display("tcp_connection_state_tracker_tb: done, errors");
      $finish;
   end

endmodule
